// File: sv/rpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types and constants of the region pool allocator: register indexes,
// status codes, the block table entry, and the controller/datapath link.
// ----------------------------------------------------------------------------
package rpa_pkg;

  localparam int unsigned SizeW  = 24;
  localparam int unsigned BytesW = 16;
  localparam int unsigned TotalW = 32;
  localparam int unsigned StatW  = 3;
  localparam int unsigned BlkW   = 4;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_BYTES  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_RESERVE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RECORD_BYTES = 2'd2;

  localparam logic [15:0] BLOCK_BYTES_RST   = 16'd4096;
  localparam logic [7:0]  FIRST_RESERVE_RST = 8'd32;
  localparam logic [7:0]  RECORD_BYTES_RST  = 8'd32;

  // result status codes
  localparam logic [StatW-1:0] ST_PLACED     = 3'd0;
  localparam logic [StatW-1:0] ST_OUT_SLOT   = 3'd1;
  localparam logic [StatW-1:0] ST_OUT_NEWREC = 3'd2;
  localparam logic [StatW-1:0] ST_NO_BLOCK   = 3'd3;
  localparam logic [StatW-1:0] ST_RESET_DONE = 3'd4;

  localparam logic [1:0] MISS_MAX   = 2'd3;
  localparam logic [1:0] RECORD_FULL = 2'd3;

  typedef struct packed {
    logic [BytesW-1:0] left;
    logic [1:0]        miss;
  } entry_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLR_WR,
    OP_CLR_END,
    OP_FILL,
    OP_RD,
    OP_NEXT,
    OP_HIT,
    OP_SLOT,
    OP_FAIL,
    OP_APPEND,
    OP_WRD,
    OP_WWR,
    OP_WEND,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic act;          // latched action is a pool reset
    logic big;          // request exceeds block_bytes
    logic need_rec;     // no open record slot
    logic rec_too_big;  // record cannot fit any block
    logic idx_lt_n;     // scan index inside the chain
    logic hit;          // block just read has room
    logic full;         // chain at maximum length
    logic cand_lt_n;    // walk candidate inside the old chain
    logic last_end;     // walk reached the chain end
  } sts_t;

endpackage

// File: sv/rpa_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_req_if
// Request channel: valid/ready with action and allocation size.
// ----------------------------------------------------------------------------
interface rpa_req_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic [rpa_pkg::SizeW-1:0]        alloc_size;

  modport source (output valid, output action, output alloc_size, input ready);
  modport sink   (input valid, input action, input alloc_size, output ready);
endinterface

// File: sv/rpa_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_rsp_if
// Result channel: valid/ready with status, block, offset and outside total.
// ----------------------------------------------------------------------------
interface rpa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [rpa_pkg::StatW-1:0]   status;
  logic [rpa_pkg::BlkW-1:0]    block_index;
  logic [rpa_pkg::BytesW-1:0]  offset;
  logic [rpa_pkg::TotalW-1:0]  outside_total;

  modport source (output valid, output status, output block_index, output offset,
                  output outside_total, input ready);
  modport sink   (input valid, input status, input block_index, input offset,
                  input outside_total, output ready);
endinterface

// File: sv/region_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_pool_allocator
// Region allocator over a chain of up to MAX_BLOCKS equal blocks, with
// outside allocations tracked in three-slot records placed in the pool.
// ----------------------------------------------------------------------------
// One item is worked at a time; each item gives exactly one result. The
// controller visits the block table one block at a time, reading each
// block's entry and then checking or updating it. An allocate that fits the
// current block is decided, read and placed; each further block scanned adds
// a read and a check, and an append adds a read and a write per block walked
// from the current block to the chain end. An outside request that uses an
// open record slot is settled without a scan, and a pool reset clears each
// block in use. A new request is taken while the last result still waits on
// the result channel.
module region_pool_allocator #(
  parameter int unsigned MAX_BLOCKS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rpa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rpa_pkg::BytesW-1:0]   cfg_data_i,
  rpa_req_if.sink                      req,
  rpa_rsp_if.source                    rsp
);

  rpa_pkg::cmd_t cmd;
  rpa_pkg::sts_t sts;

  rpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_action_i     (req.action),
    .in_size_i       (req.alloc_size),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .status_o        (rsp.status),
    .block_index_o   (rsp.block_index),
    .offset_o        (rsp.offset),
    .outside_total_o (rsp.outside_total)
  );

endmodule

// File: sv/rpa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_dp
// Allocator datapath: configuration registers, pool state, block table
// memory and result registers, driven one command per cycle.
// ----------------------------------------------------------------------------
module rpa_dp #(
  parameter int unsigned MAX_BLOCKS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rpa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rpa_pkg::BytesW-1:0]    cfg_data_i,
  input  logic                          in_action_i,
  input  logic [rpa_pkg::SizeW-1:0]     in_size_i,
  input  rpa_pkg::cmd_t                 cmd_i,
  output rpa_pkg::sts_t                 sts_o,
  output logic [rpa_pkg::StatW-1:0]     status_o,
  output logic [rpa_pkg::BlkW-1:0]      block_index_o,
  output logic [rpa_pkg::BytesW-1:0]    offset_o,
  output logic [rpa_pkg::TotalW-1:0]    outside_total_o
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

  // configuration
  logic [15:0] blk_bytes_q;
  logic [7:0]  reserve_q;
  logic [7:0]  rec_bytes_q;

  // pool state
  logic [CW-1:0]               n_q, n_d;
  logic [IW-1:0]               cur_q, cur_d;
  logic [1:0]                  fill_q, fill_d;
  logic [rpa_pkg::TotalW-1:0]  sum_q, sum_d;
  logic                        init_q, init_d;

  // work registers
  logic                        act_q, act_d;
  logic [rpa_pkg::SizeW-1:0]   size_q, size_d;
  logic [15:0]                 psize_q, psize_d;
  logic [CW-1:0]               idx_q, idx_d;
  logic [CW-1:0]               cand_q, cand_d;
  logic [CW-1:0]               last_q, last_d;
  logic [rpa_pkg::StatW-1:0]   res_st_q, res_st_d;
  logic [rpa_pkg::BlkW-1:0]    res_blk_q, res_blk_d;
  logic [15:0]                 res_off_q, res_off_d;
  logic [rpa_pkg::StatW-1:0]   out_st_q, out_st_d;
  logic [rpa_pkg::BlkW-1:0]    out_blk_q, out_blk_d;
  logic [15:0]                 out_off_q, out_off_d;
  logic [rpa_pkg::TotalW-1:0]  out_sum_q, out_sum_d;

  // block table
  rpa_pkg::entry_t mem [MAX_BLOCKS];
  rpa_pkg::entry_t rd_q;
  rpa_pkg::entry_t mem_wdata;
  logic            mem_we, mem_re;
  logic [IW-1:0]   mem_waddr, mem_raddr;

  logic [15:0]                 cap0, cap_idx, off_val;
  logic                        big, hit;
  logic [rpa_pkg::TotalW:0]    sum_add;
  logic [rpa_pkg::TotalW-1:0]  sum_sat;
  logic [CW:0]                 last_inc;
  logic [1:0]                  miss_inc;

  assign cap0     = (blk_bytes_q > 16'(reserve_q)) ? blk_bytes_q - 16'(reserve_q) : 16'd0;
  assign cap_idx  = (idx_q == '0) ? cap0 : blk_bytes_q;
  assign off_val  = (cap_idx > rd_q.left) ? cap_idx - rd_q.left : 16'd0;
  assign big      = size_q > rpa_pkg::SizeW'(blk_bytes_q);
  assign hit      = rd_q.left >= psize_q;
  assign sum_add  = {1'b0, sum_q} + (rpa_pkg::TotalW + 1)'(size_q);
  assign sum_sat  = sum_add[rpa_pkg::TotalW] ? '1 : sum_add[rpa_pkg::TotalW-1:0];
  assign last_inc = {1'b0, last_q} + (CW + 1)'(1);
  assign miss_inc = (rd_q.miss == rpa_pkg::MISS_MAX) ? rpa_pkg::MISS_MAX : rd_q.miss + 2'd1;

  always_comb begin
    sts_o.act         = act_q;
    sts_o.big         = big;
    sts_o.need_rec    = (fill_q == 2'd0) || (fill_q == rpa_pkg::RECORD_FULL);
    sts_o.rec_too_big = 16'(rec_bytes_q) > blk_bytes_q;
    sts_o.idx_lt_n    = idx_q < n_q;
    sts_o.hit         = hit;
    sts_o.full        = n_q >= CW'(MAX_BLOCKS);
    sts_o.cand_lt_n   = cand_q < n_q;
    sts_o.last_end    = last_inc >= {1'b0, n_q};
  end

  always_comb begin
    n_d       = n_q;
    cur_d     = cur_q;
    fill_d    = fill_q;
    sum_d     = sum_q;
    init_d    = init_q;
    act_d     = act_q;
    size_d    = size_q;
    psize_d   = psize_q;
    idx_d     = idx_q;
    cand_d    = cand_q;
    last_d    = last_q;
    res_st_d  = res_st_q;
    res_blk_d = res_blk_q;
    res_off_d = res_off_q;
    out_st_d  = out_st_q;
    out_blk_d = out_blk_q;
    out_off_d = out_off_q;
    out_sum_d = out_sum_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q[IW-1:0];
    mem_wdata = '{left: cap_idx, miss: 2'd0};
    mem_re    = 1'b0;
    mem_raddr = idx_q[IW-1:0];
    unique case (cmd_i.op)
      rpa_pkg::OP_LOAD: begin
        act_d  = in_action_i;
        size_d = in_size_i;
        idx_d  = '0;
      end
      rpa_pkg::OP_CLR_WR: begin
        mem_we = 1'b1;
        idx_d  = idx_q + CW'(1);
      end
      rpa_pkg::OP_CLR_END: begin
        cur_d     = '0;
        fill_d    = 2'd0;
        sum_d     = '0;
        init_d    = 1'b0;
        res_st_d  = rpa_pkg::ST_RESET_DONE;
        res_blk_d = '0;
        res_off_d = '0;
      end
      rpa_pkg::OP_FILL: begin
        if (init_q) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = '{left: cap0, miss: 2'd0};
          init_d    = 1'b0;
        end
        psize_d = big ? 16'(rec_bytes_q) : size_q[15:0];
        idx_d   = CW'(cur_q);
      end
      rpa_pkg::OP_RD: begin
        mem_re = 1'b1;
      end
      rpa_pkg::OP_NEXT: begin
        idx_d = idx_q + CW'(1);
      end
      rpa_pkg::OP_HIT: begin
        mem_we    = 1'b1;
        mem_wdata = '{left: rd_q.left - psize_q, miss: rd_q.miss};
        res_st_d  = big ? rpa_pkg::ST_OUT_NEWREC : rpa_pkg::ST_PLACED;
        res_blk_d = rpa_pkg::BlkW'(idx_q);
        res_off_d = off_val;
        if (big) begin
          fill_d = 2'd1;
          sum_d  = sum_sat;
        end
      end
      rpa_pkg::OP_SLOT: begin
        fill_d    = fill_q + 2'd1;
        sum_d     = sum_sat;
        res_st_d  = rpa_pkg::ST_OUT_SLOT;
        res_blk_d = '0;
        res_off_d = '0;
      end
      rpa_pkg::OP_FAIL: begin
        res_st_d  = rpa_pkg::ST_NO_BLOCK;
        res_blk_d = '0;
        res_off_d = '0;
      end
      rpa_pkg::OP_APPEND: begin
        mem_we    = 1'b1;
        mem_waddr = n_q[IW-1:0];
        mem_wdata = '{left: blk_bytes_q - psize_q, miss: 2'd0};
        cand_d    = CW'(cur_q);
        last_d    = CW'(cur_q);
      end
      rpa_pkg::OP_WRD: begin
        mem_re    = 1'b1;
        mem_raddr = cand_q[IW-1:0];
      end
      rpa_pkg::OP_WWR: begin
        if (cand_q < n_q) begin
          mem_we    = 1'b1;
          mem_waddr = cand_q[IW-1:0];
          mem_wdata = '{left: rd_q.left, miss: miss_inc};
          if (rd_q.miss == rpa_pkg::MISS_MAX) begin
            cand_d = last_inc[CW-1:0];
          end
        end
        last_d = last_inc[CW-1:0];
      end
      rpa_pkg::OP_WEND: begin
        n_d       = n_q + CW'(1);
        cur_d     = (cand_q <= n_q) ? cand_q[IW-1:0] : n_q[IW-1:0];
        res_st_d  = big ? rpa_pkg::ST_OUT_NEWREC : rpa_pkg::ST_PLACED;
        res_blk_d = rpa_pkg::BlkW'(n_q);
        res_off_d = '0;
        if (big) begin
          fill_d = 2'd1;
          sum_d  = sum_sat;
        end
      end
      rpa_pkg::OP_EMIT: begin
        out_st_d  = res_st_q;
        out_blk_d = res_blk_q;
        out_off_d = res_off_q;
        out_sum_d = sum_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_bytes_q <= rpa_pkg::BLOCK_BYTES_RST;
      reserve_q   <= rpa_pkg::FIRST_RESERVE_RST;
      rec_bytes_q <= rpa_pkg::RECORD_BYTES_RST;
      n_q         <= CW'(1);
      cur_q       <= '0;
      fill_q      <= 2'd0;
      sum_q       <= '0;
      init_q      <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rpa_pkg::CFG_BLOCK_BYTES:   blk_bytes_q <= cfg_data_i;
          rpa_pkg::CFG_FIRST_RESERVE: reserve_q   <= cfg_data_i[7:0];
          rpa_pkg::CFG_RECORD_BYTES:  rec_bytes_q <= cfg_data_i[7:0];
          default: begin
          end
        endcase
      end
      n_q    <= n_d;
      cur_q  <= cur_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
      init_q <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    size_q    <= size_d;
    psize_q   <= psize_d;
    idx_q     <= idx_d;
    cand_q    <= cand_d;
    last_q    <= last_d;
    res_st_q  <= res_st_d;
    res_blk_q <= res_blk_d;
    res_off_q <= res_off_d;
    out_st_q  <= out_st_d;
    out_blk_q <= out_blk_d;
    out_off_q <= out_off_d;
    out_sum_q <= out_sum_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign status_o        = out_st_q;
  assign block_index_o   = out_blk_q;
  assign offset_o        = out_off_q;
  assign outside_total_o = out_sum_q;

endmodule

// File: sv/rpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_ctrl
// Allocator controller: sequences pool reset, block scan, append with the
// miss count walk, and the result transfer.
// ----------------------------------------------------------------------------
module rpa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  rpa_pkg::sts_t  sts_i,
  output rpa_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_CLR,
    S_FILL,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_WALK_RD,
    S_WALK_WR,
    S_WALK_END,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = rpa_pkg::OP_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = rpa_pkg::OP_LOAD;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = sts_i.act ? S_CLR : S_FILL;
      end
      S_CLR: begin
        if (sts_i.idx_lt_n) begin
          cmd_o.op = rpa_pkg::OP_CLR_WR;
        end else begin
          cmd_o.op = rpa_pkg::OP_CLR_END;
          state_d  = S_RESP;
        end
      end
      S_FILL: begin
        priority if (!sts_i.big) begin
          cmd_o.op = rpa_pkg::OP_FILL;
          state_d  = S_SCAN_RD;
        end else if (!sts_i.need_rec) begin
          cmd_o.op = rpa_pkg::OP_FILL;
          state_d  = S_RESP;
        end else if (sts_i.rec_too_big) begin
          cmd_o.op = rpa_pkg::OP_FILL;
          state_d  = S_RESP;
        end else begin
          cmd_o.op = rpa_pkg::OP_FILL;
          state_d  = S_SCAN_RD;
        end
        // outside results without a scan are settled on the way to S_RESP
        if (sts_i.big && !sts_i.need_rec) begin
          state_d = S_WALK_END;
        end
        if (sts_i.big && sts_i.need_rec && sts_i.rec_too_big) begin
          state_d = S_WALK_END;
        end
      end
      S_SCAN_RD: begin
        priority if (sts_i.idx_lt_n) begin
          cmd_o.op = rpa_pkg::OP_RD;
          state_d  = S_SCAN_CHK;
        end else if (sts_i.full) begin
          cmd_o.op = rpa_pkg::OP_FAIL;
          state_d  = S_RESP;
        end else begin
          cmd_o.op = rpa_pkg::OP_APPEND;
          state_d  = S_WALK_RD;
        end
      end
      S_SCAN_CHK: begin
        if (sts_i.hit) begin
          cmd_o.op = rpa_pkg::OP_HIT;
          state_d  = S_RESP;
        end else begin
          cmd_o.op = rpa_pkg::OP_NEXT;
          state_d  = S_SCAN_RD;
        end
      end
      S_WALK_RD: begin
        cmd_o.op = rpa_pkg::OP_WRD;
        state_d  = S_WALK_WR;
      end
      S_WALK_WR: begin
        cmd_o.op = rpa_pkg::OP_WWR;
        state_d  = sts_i.last_end ? S_WALK_END : S_WALK_RD;
      end
      S_WALK_END: begin
        // reached from the walk, or straight from S_FILL for outside requests
        priority if (!sts_i.big) begin
          cmd_o.op = rpa_pkg::OP_WEND;
        end else if (!sts_i.need_rec) begin
          cmd_o.op = rpa_pkg::OP_SLOT;
        end else if (sts_i.rec_too_big) begin
          cmd_o.op = rpa_pkg::OP_FAIL;
        end else begin
          cmd_o.op = rpa_pkg::OP_WEND;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.op    = rpa_pkg::OP_EMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
